### rtl/core/bpm_pkg.sv
`timescale 1ns / 1ps

package bpm_pkg;

  // Sizing of the matcher
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int OFFSET_BITS       = 32;
  localparam int WINDOW_BYTES      = 8;
  localparam int LEN_LIMIT         = (MAX_PATTERN_BYTES < WINDOW_BYTES) ?
                                     MAX_PATTERN_BYTES : WINDOW_BYTES;
  localparam int CELL_IDX_W        = $clog2(MAX_PATTERN_BYTES);

  // Field widths
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 4;
  localparam int PATTERN_W    = 64;
  localparam int MATCH_OFF_W  = 32;
  localparam int MATCH_NUM_W  = 32;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(1);

  typedef logic [BYTE_W-1:0]                        byte_t;
  typedef logic [LEN_W-1:0]                         len_t;
  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] pattern_t;
  typedef logic [OFFSET_BITS-1:0]                   pos_t;
  typedef logic [MATCH_NUM_W-1:0]                   count_t;

  // Control handed from the top level to every cell of the window
  typedef struct packed {
    logic advance;  // a byte is taken this cycle
    logic clear;    // the byte closes the buffer
    len_t len;      // pattern length in use
  } cell_ctrl_t;

endpackage

### rtl/core/bpm_if.sv
`timescale 1ns / 1ps

// Input byte channel
interface bpm_in_if import bpm_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_in_buffer;

  modport source (output valid, output data_byte, output last_in_buffer, input ready);
  modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

// Match result channel
interface bpm_out_if import bpm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MATCH_OFF_W-1:0] match_offset;
  logic [MATCH_NUM_W-1:0] match_number;

  modport source (output valid, output match_offset, output match_number, input ready);
  modport sink   (input valid, input match_offset, input match_number, output ready);
endinterface

// Register write channel
interface bpm_cfg_if import bpm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/byte_pattern_matcher_core.sv
`timescale 1ns / 1ps
// A match is on out_ch in the cycle after the beat carrying its last byte is accepted.
// Throughput: one byte per cycle; the window compare is a single row of cells.
// in_ch stalls only while a result is held and out_ch is not ready.
// Reset (rst_n, synchronous, active low) clears the window, position, match count,
// pattern and length registers and the output valid flag; offset and number are not reset.

module byte_pattern_matcher_core import bpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bpm_in_if.sink    in_ch,
  bpm_out_if.source out_ch,
  bpm_cfg_if.sink   cfg_ch
);

  pattern_t   pattern;
  len_t       pattern_len;
  cell_ctrl_t ctrl;
  logic       accept;
  byte_t      byte_link  [MAX_PATTERN_BYTES];
  logic       match_link [MAX_PATTERN_BYTES+1];

  pos_t       seen_r, seen_nxt;
  count_t     cnt_r, cnt_nxt;
  count_t     cnt_inc;
  pos_t       off_full;
  logic       len_ok, seen_ok, hit;

  logic                   out_valid_r, out_valid_nxt;
  logic [MATCH_OFF_W-1:0] out_offset_r, out_offset_nxt;
  count_t                 out_number_r, out_number_nxt;

  // Configuration registers
  bpm_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .pattern     (pattern),
    .pattern_len (pattern_len)
  );

  // Input handshake: take a beat whenever the output stage is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ctrl.advance = accept;
  assign ctrl.clear   = in_ch.last_in_buffer;
  assign ctrl.len     = pattern_len;

  // Row of window cells
  assign byte_link[0]  = in_ch.data_byte;
  assign match_link[0] = 1'b1;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    if (i < MAX_PATTERN_BYTES - 1) begin : g_mid
      bpm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cell_idx  (CELL_IDX_W'(i)),
        .pattern   (pattern),
        .byte_in   (byte_link[i]),
        .byte_out  (byte_link[i+1]),
        .match_in  (match_link[i]),
        .match_out (match_link[i+1])
      );
    end else begin : g_end
      bpm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cell_idx  (CELL_IDX_W'(i)),
        .pattern   (pattern),
        .byte_in   (byte_link[i]),
        .byte_out  (),
        .match_in  (match_link[i]),
        .match_out (match_link[i+1])
      );
    end
  end

  // Position, gating and match count
  always_comb begin
    seen_nxt = (seen_r == '1) ? seen_r : seen_r + OFFSET_BITS'(1);
    len_ok   = (pattern_len != '0) && (pattern_len <= LEN_W'(LEN_LIMIT));
    seen_ok  = seen_nxt >= OFFSET_BITS'(pattern_len);
    hit      = accept && len_ok && seen_ok && match_link[MAX_PATTERN_BYTES];
    cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + MATCH_NUM_W'(1);
    off_full = seen_nxt - OFFSET_BITS'(pattern_len);
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (in_ch.last_in_buffer) begin
        cnt_nxt = '0;
      end else if (hit) begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // Output stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_offset_nxt = out_offset_r;
    out_number_nxt = out_number_r;
    if (hit) begin
      out_valid_nxt  = 1'b1;
      out_offset_nxt = off_full[MATCH_OFF_W-1:0];
      out_number_nxt = cnt_inc;
    end else if (out_ch.ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        seen_r <= in_ch.last_in_buffer ? '0 : seen_nxt;
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_offset_r <= out_offset_nxt;
    out_number_r <= out_number_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.match_offset = out_offset_r;
  assign out_ch.match_number = out_number_r;

`ifndef SYNTHESIS
  // A closing byte leaves the position and count at zero
  a_buffer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_in_buffer |=> seen_r == '0 && cnt_r == '0)
    else $error("position or count not cleared after last byte");

  // Length zero never produces a result
  a_len_zero_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pattern_len == '0 |=> !out_valid_r)
    else $error("result with pattern length zero");

  // Every reported match carries a count of at least one
  a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_number_r != '0)
    else $error("result with zero match number");

  // Position advances by one per byte until saturation
  a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.last_in_buffer && seen_r != '1 |=> seen_r == $past(seen_r) + 1'b1)
    else $error("position did not advance");
`endif

endmodule

### rtl/core/bpm_cell.sv
`timescale 1ns / 1ps

// One byte of the sliding window. Cell j holds the byte received j+1 beats ago
// and checks the byte shifting into it against pattern byte len-1-j.
module bpm_cell import bpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [CELL_IDX_W-1:0] cell_idx,
  input  pattern_t              pattern,
  input  byte_t                 byte_in,
  output byte_t                 byte_out,
  input  logic                  match_in,
  output logic                  match_out
);

  byte_t                 byte_r;
  logic                  in_use;
  len_t                  sel_full;
  logic [CELL_IDX_W-1:0] sel;
  logic                  eq;

  // Compare against the pattern byte that lines up with this cell
  always_comb begin
    in_use   = LEN_W'(cell_idx) < ctrl.len;
    sel_full = ctrl.len - LEN_W'(cell_idx) - LEN_W'(1);
    sel      = sel_full[CELL_IDX_W-1:0];
    eq       = !in_use || (byte_in == pattern[sel]);
  end

  assign match_out = match_in && eq;
  assign byte_out  = byte_r;

  // Shift the window one byte per beat; a closing byte empties it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctrl.advance) begin
      byte_r <= ctrl.clear ? '0 : byte_in;
    end
  end

endmodule

### rtl/core/bpm_cfg_regs.sv
`timescale 1ns / 1ps

// Pattern and length registers behind the write channel
module bpm_cfg_regs import bpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bpm_cfg_if.sink   cfg_ch,
  output pattern_t  pattern,
  output len_t      pattern_len
);

  pattern_t pattern_r;
  len_t     len_r;
  logic     wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign pattern      = pattern_r;
  assign pattern_len  = len_r;

  // Register decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= '0;
    end else if (wr_en) begin
      unique case (cfg_ch.reg_index)
        REG_PATTERN_BYTES:  pattern_r <= pattern_t'(cfg_ch.wr_data[PATTERN_W-1:0]);
        REG_PATTERN_LENGTH: len_r     <= cfg_ch.wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bpm_pkg::*;

  // Index with no register behind it: writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(15);
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned BEATS_PER_PHASE = 70;

  typedef struct packed {
    byte_t data;
    logic  last;
  } beat_t;

  typedef struct packed {
    logic [MATCH_OFF_W-1:0] offset;
    count_t                 number;
  } hit_t;

  logic clk;
  logic rst_n;

  bpm_in_if  in_ch ();
  bpm_out_if out_ch ();
  bpm_cfg_if cfg_ch ();

  byte_pattern_matcher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Own copy of the matcher: registers and scan state
  logic [PATTERN_W-1:0] pattern_reg = '0;
  len_t                 length_reg  = '0;
  logic [PATTERN_W-1:0] window      = '0;
  pos_t                 seen        = '0;
  count_t               found       = '0;

  beat_t       beats_to_send[$];
  hit_t        hits_due[$];
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned in_gap        = 0;
  int unsigned out_gap       = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  beat_t       next_beat;
  hit_t        want;

  // Shift one byte into the window and work out whether the pattern ends here
  function automatic void scan_byte(byte_t b, logic last);
    int   k;
    logic hit;
    hit_t h;
    window = {window[PATTERN_W-BYTE_W-1:0], b};
    if (seen != '1) seen++;
    hit = (length_reg >= 1) && (length_reg <= LEN_LIMIT) && (seen >= length_reg);
    for (k = 0; k < LEN_LIMIT; k++) begin
      // pattern byte k sits length-1-k bytes back from the newest
      if (hit && k < length_reg) begin
        if (window[BYTE_W*(length_reg-1-k) +: BYTE_W] != pattern_reg[BYTE_W*k +: BYTE_W])
          hit = 1'b0;
      end
    end
    if (hit) begin
      if (found != '1) found++;
      h.offset = MATCH_OFF_W'(seen - length_reg);
      h.number = found;
      hits_due = {hits_due, h};
    end
    if (last) begin
      window = '0;
      seen   = '0;
      found  = '0;
    end
  endfunction

  function automatic void push_beat(byte_t b, logic last);
    beat_t bt;
    bt.data = b;
    bt.last = last;
    beats_to_send = {beats_to_send, bt};
  endfunction

  // One buffer of at least n bytes; mostly pattern copies (some spoilt) and pattern bytes, all random with noise
  function automatic void add_buffer(int unsigned n, bit noise);
    byte_t       bytes_q[$];
    byte_t       b;
    int unsigned j;
    int unsigned spot;
    int unsigned pick;
    while (bytes_q.size() < n) begin
      if (!noise && length_reg >= 1 && length_reg <= LEN_LIMIT &&
          $urandom_range(0, 99) < 35) begin
        spot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, length_reg - 1) : LEN_LIMIT;
        for (j = 0; j < length_reg; j++) begin
          b = pattern_reg[BYTE_W*j +: BYTE_W];
          if (j == spot) b ^= byte_t'($urandom_range(1, 255));
          bytes_q = {bytes_q, b};
        end
      end else if (!noise && $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, LEN_LIMIT - 1);
        bytes_q = {bytes_q, byte_t'(pattern_reg[BYTE_W*pick +: BYTE_W])};
      end else begin
        bytes_q = {bytes_q, byte_t'($urandom)};
      end
    end
    for (j = 0; j < bytes_q.size(); j++) push_beat(bytes_q[j], j == bytes_q.size() - 1);
  endfunction

  function automatic int unsigned idle_pick();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_PATTERN_BYTES) pattern_reg = val;
    else if (idx == REG_PATTERN_LENGTH) length_reg = val[LEN_W-1:0];
  endtask

  // Length write with junk in the unused upper bits
  task automatic write_length(len_t len);
    logic [CFG_DATA_W-1:0] val;
    val = {$urandom, $urandom};
    val[LEN_W-1:0] = len;
    write_reg(REG_PATTERN_LENGTH, val);
  endtask

  // Block is idle once every beat is in and every match is out
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_ch.valid || hits_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[byte_pattern_matcher_core] ERROR");
      $finish;
    end
  end

  // Byte driver: predicts on every accepted beat, then loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.last_in_buffer);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (beats_to_send.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 17) - 1;
          in_ch.valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          next_beat = beats_to_send.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.data_byte      <= next_beat.data;
          in_ch.last_in_buffer <= next_beat.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Match monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected match: offset %0d number %0d",
                     out_ch.match_offset, out_ch.match_number);
        end else begin
          want = hits_due.pop_front();
          if (out_ch.match_offset !== want.offset || out_ch.match_number !== want.number) begin
            mismatches++;
            if (mismatches <= 10)
              $display("match mismatch: offset exp %0d got %0d, number exp %0d got %0d",
                       want.offset, out_ch.match_offset, want.number, out_ch.match_number);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_gap = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and sequencing
  initial begin
    logic [PATTERN_W-1:0] pat;
    byte_t                sym_a;
    byte_t                sym_b;
    len_t                 len;
    int unsigned          p;
    int unsigned          k;
    int unsigned          r;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.last_in_buffer = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = '0;
    cfg_ch.wr_data       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct   = 20;
    out_stall_pct = 20;

    // Length zero out of reset: zeros must not match the zero pattern
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // Two zero bytes: overlapping matches, none before two bytes are in
    write_reg(REG_PATTERN_BYTES, '0);
    write_length(len_t'(2));
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // Full-width all-ones pattern
    write_reg(REG_PATTERN_BYTES, '1);
    write_length(len_t'(LEN_LIMIT));
    for (k = 0; k < 9; k++) push_beat(8'hFF, k == 8);
    wait_idle();

    // Lengths past the window never match
    write_length(len_t'(LEN_LIMIT + 1));
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, '1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // Unused index dropped; window kept across a pattern change
    pat = {$urandom, $urandom};
    pat[7:0] = 8'hAB;
    write_reg(REG_PATTERN_BYTES, pat);
    write_length(len_t'(1));
    write_reg(REG_UNUSED, '0);
    push_beat(8'hAB, 1'b0);
    wait_idle();
    pat[15:8] = 8'hCD;
    write_reg(REG_PATTERN_BYTES, pat);
    write_length(len_t'(2));
    push_beat(8'hCD, 1'b1);
    wait_idle();

    // Random phases, each with its own pattern, length and idling
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct   = idle_pick();
        out_stall_pct = idle_pick();
      end

      sym_a = byte_t'($urandom);
      sym_b = byte_t'($urandom);
      case ($urandom_range(0, 2))
        0: pat = {$urandom, $urandom};
        1: for (k = 0; k < LEN_LIMIT; k++)
             pat[BYTE_W*k +: BYTE_W] = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
        default: pat = {LEN_LIMIT{sym_a}};
      endcase

      r = $urandom_range(0, 19);
      if (r == 0) len = '0;
      else if (r == 1) len = len_t'($urandom_range(LEN_LIMIT + 1, 15));
      else if (r < 4) len = len_t'(LEN_LIMIT);
      else len = len_t'($urandom_range(1, LEN_LIMIT));

      write_reg(REG_PATTERN_BYTES, pat);
      write_length(len);

      while (beats_to_send.size() < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 29) == 0) add_buffer($urandom_range(64, 300), 1'b0);
        else add_buffer($urandom_range(1, 24), $urandom_range(0, 9) == 0);
      end
      wait_idle();
    end

    if (hits_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[byte_pattern_matcher_core] OK");
    end else begin
      $display("[byte_pattern_matcher_core] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bpm_pkg.sv
rtl/core/bpm_if.sv
rtl/core/bpm_cell.sv
rtl/core/bpm_cfg_regs.sv
rtl/core/byte_pattern_matcher_core.sv
dv/tb.sv
